@@ rtl/core/sit_pkg.sv @@
package sit_pkg;

  // field widths fixed by the item format
  localparam int unsigned FieldW = 16;
  localparam int unsigned TolW = 16;
  localparam logic [TolW-1:0] TolReset = 16'd7;

  // default coordinate width
  localparam int unsigned CoordBitsDefault = 16;

  // number of orientation determinants per pair
  localparam int unsigned NumDet = 4;

  typedef struct packed {
    logic signed [FieldW-1:0] first_start_x;
    logic signed [FieldW-1:0] first_start_y;
    logic signed [FieldW-1:0] first_end_x;
    logic signed [FieldW-1:0] first_end_y;
    logic signed [FieldW-1:0] second_start_x;
    logic signed [FieldW-1:0] second_start_y;
    logic signed [FieldW-1:0] second_end_x;
    logic signed [FieldW-1:0] second_end_y;
  } pair_t;

endpackage

@@ rtl/core/sit_pair_if.sv @@
interface sit_pair_if;
  import sit_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [FieldW-1:0] first_start_x;
  logic signed [FieldW-1:0] first_start_y;
  logic signed [FieldW-1:0] first_end_x;
  logic signed [FieldW-1:0] first_end_y;
  logic signed [FieldW-1:0] second_start_x;
  logic signed [FieldW-1:0] second_start_y;
  logic signed [FieldW-1:0] second_end_x;
  logic signed [FieldW-1:0] second_end_y;

  modport source (
    output valid, first_start_x, first_start_y, first_end_x, first_end_y,
           second_start_x, second_start_y, second_end_x, second_end_y,
    input  ready
  );

  modport sink (
    input  valid, first_start_x, first_start_y, first_end_x, first_end_y,
           second_start_x, second_start_y, second_end_x, second_end_y,
    output ready
  );
endinterface

@@ rtl/core/sit_result_if.sv @@
interface sit_result_if;
  logic valid;
  logic ready;
  logic segments_meet;

  modport source (
    output valid, segments_meet,
    input  ready
  );

  modport sink (
    input  valid, segments_meet,
    output ready
  );
endinterface

@@ rtl/core/sit_front.sv @@
module sit_front #(
  parameter int unsigned COORD_BITS = sit_pkg::CoordBitsDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  sit_pkg::pair_t         pair_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic signed [COORD_BITS:0] opd_o [sit_pkg::NumDet][4],
  output logic [sit_pkg::NumDet-1:0] in_box_o
);
  import sit_pkg::*;

  localparam int unsigned CW = COORD_BITS;

  logic [FieldW-1:0]     fld [8];
  logic signed [CW-1:0]  crd [8];
  logic signed [CW-1:0]  ax [NumDet];
  logic signed [CW-1:0]  ay [NumDet];
  logic signed [CW-1:0]  bx [NumDet];
  logic signed [CW-1:0]  by [NumDet];
  logic signed [CW-1:0]  px [NumDet];
  logic signed [CW-1:0]  py [NumDet];
  logic signed [CW:0]    opd_d [NumDet][4];
  logic signed [CW:0]    opd_q [NumDet][4];
  logic [NumDet-1:0]     box_d, box_q;
  logic                  valid_q;
  logic                  load;

  assign fld[0] = pair_i.first_start_x;
  assign fld[1] = pair_i.first_start_y;
  assign fld[2] = pair_i.first_end_x;
  assign fld[3] = pair_i.first_end_y;
  assign fld[4] = pair_i.second_start_x;
  assign fld[5] = pair_i.second_start_y;
  assign fld[6] = pair_i.second_end_x;
  assign fld[7] = pair_i.second_end_y;

  // coordinate is the low bits of the field, or the field sign-extended
  for (genvar g = 0; g < 8; g++) begin : g_crd
    if (CW <= FieldW) begin : g_cut
      assign crd[g] = $signed(fld[g][CW-1:0]);
    end else begin : g_ext
      assign crd[g] = $signed({{(CW-FieldW){fld[g][FieldW-1]}}, fld[g]});
    end
  end

  // first segment against both second endpoints, then the reverse
  always_comb begin
    ax[0] = crd[0]; ay[0] = crd[1]; bx[0] = crd[2]; by[0] = crd[3];
    px[0] = crd[4]; py[0] = crd[5];
    ax[1] = crd[0]; ay[1] = crd[1]; bx[1] = crd[2]; by[1] = crd[3];
    px[1] = crd[6]; py[1] = crd[7];
    ax[2] = crd[4]; ay[2] = crd[5]; bx[2] = crd[6]; by[2] = crd[7];
    px[2] = crd[0]; py[2] = crd[1];
    ax[3] = crd[4]; ay[3] = crd[5]; bx[3] = crd[6]; by[3] = crd[7];
    px[3] = crd[2]; py[3] = crd[3];
  end

  always_comb begin
    for (int k = 0; k < NumDet; k++) begin
      opd_d[k][0] = (CW+1)'(py[k]) - (CW+1)'(ay[k]);
      opd_d[k][1] = (CW+1)'(bx[k]) - (CW+1)'(ax[k]);
      opd_d[k][2] = (CW+1)'(by[k]) - (CW+1)'(ay[k]);
      opd_d[k][3] = (CW+1)'(px[k]) - (CW+1)'(ax[k]);
      // closed bounding box without picking min and max
      box_d[k] = (px[k] >= ax[k] || px[k] >= bx[k]) &&
                 (px[k] <= ax[k] || px[k] <= bx[k]) &&
                 (py[k] >= ay[k] || py[k] >= by[k]) &&
                 (py[k] <= ay[k] || py[k] <= by[k]);
    end
  end

  assign in_ready_o = !valid_q || out_ready_i;
  assign load       = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      opd_q <= opd_d;
      box_q <= box_d;
    end
  end

  assign out_valid_o = valid_q;
  assign opd_o       = opd_q;
  assign in_box_o    = box_q;

endmodule

@@ rtl/core/sit_orient.sv @@
module sit_orient #(
  parameter int unsigned COORD_BITS = sit_pkg::CoordBitsDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [COORD_BITS:0]   opd_i [sit_pkg::NumDet][4],
  input  logic [sit_pkg::NumDet-1:0]   in_box_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [2*COORD_BITS+2:0] det_o [sit_pkg::NumDet],
  output logic [sit_pkg::NumDet-1:0]   in_box_o
);
  import sit_pkg::*;

  localparam int unsigned PW = 2 * COORD_BITS + 2;
  localparam int unsigned DW = PW + 1;

  logic signed [PW-1:0] prod_d [NumDet][2];
  logic signed [PW-1:0] prod_q [NumDet][2];
  logic signed [DW-1:0] det_d [NumDet];
  logic signed [DW-1:0] det_q [NumDet];
  logic [NumDet-1:0]    box2_q, box3_q;
  logic                 v2_q, v3_q;
  logic                 rdy2, rdy3;

  // product stage
  always_comb begin
    for (int k = 0; k < NumDet; k++) begin
      prod_d[k][0] = opd_i[k][0] * opd_i[k][1];
      prod_d[k][1] = opd_i[k][2] * opd_i[k][3];
    end
  end

  // difference stage, exact at full width
  always_comb begin
    for (int k = 0; k < NumDet; k++) begin
      det_d[k] = DW'(prod_q[k][0]) - DW'(prod_q[k][1]);
    end
  end

  assign rdy3       = !v3_q || out_ready_i;
  assign rdy2       = !v2_q || rdy3;
  assign in_ready_o = rdy2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy2) begin
        v2_q <= in_valid_i;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2 && in_valid_i) begin
      prod_q <= prod_d;
      box2_q <= in_box_i;
    end
    if (rdy3 && v2_q) begin
      det_q  <= det_d;
      box3_q <= box2_q;
    end
  end

  assign out_valid_o = v3_q;
  assign det_o       = det_q;
  assign in_box_o    = box3_q;

  a_prod_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q && !rdy3 |=> v2_q && $stable(box2_q))
    else $error("product stage lost or changed a stalled request");

endmodule

@@ rtl/core/sit_decide.sv @@
module sit_decide #(
  parameter int unsigned COORD_BITS = sit_pkg::CoordBitsDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic signed [2*COORD_BITS+2:0] det_i [sit_pkg::NumDet],
  input  logic [sit_pkg::NumDet-1:0]     in_box_i,
  input  logic [sit_pkg::TolW-1:0]       tol_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           segments_meet_o
);
  import sit_pkg::*;

  localparam int unsigned DW    = 2 * COORD_BITS + 3;
  localparam int unsigned CMP_W = (DW > TolW + 1) ? DW : TolW + 1;

  logic signed [CMP_W-1:0] det_x [NumDet];
  logic signed [CMP_W-1:0] tol_x;
  logic [NumDet-1:0]       near, pos, neg;
  logic                    touch, crossing;
  logic                    meet_d, meet_q;
  logic                    valid_q;

  assign tol_x = $signed({{(CMP_W-TolW){1'b0}}, tol_i});

  always_comb begin
    for (int k = 0; k < NumDet; k++) begin
      det_x[k] = CMP_W'(det_i[k]);
      near[k]  = (det_x[k] <= tol_x) && (det_x[k] >= -tol_x);
      neg[k]   = det_i[k][DW-1];
      pos[k]   = !det_i[k][DW-1] && (|det_i[k]);
    end
  end

  // an endpoint on the other segment, or both pairs strictly straddling
  assign touch    = |(near & in_box_i);
  assign crossing = ((pos[0] && neg[1]) || (neg[0] && pos[1])) &&
                    ((pos[2] && neg[3]) || (neg[2] && pos[3]));
  assign meet_d   = touch || crossing;

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      meet_q <= meet_d;
    end
  end

  assign out_valid_o     = valid_q;
  assign segments_meet_o = meet_q;

  a_touch_meets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && touch |=> out_valid_o && segments_meet_o)
    else $error("endpoint on segment did not report a meet");

  a_collinear_apart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_box_i == '0 &&
    det_i[0] == '0 && det_i[1] == '0 && det_i[2] == '0 && det_i[3] == '0
    |=> out_valid_o && !segments_meet_o)
    else $error("disjoint collinear segments reported as meeting");

endmodule

@@ rtl/core/segment_intersection_test_core.sv @@
// segment pair intersection test
// pair_i carries two 2-D segments as eight signed Q8.8 coordinates; result_o
// carries one bit per request, segments_meet, set when the segments touch or
// cross. both channels use valid/ready, a request moves when both are high.
// an endpoint counts as touching when its orientation determinant is within
// the collinear tolerance (tol_we_i / tol_wdata_i, units of 2^-16) and it sits
// in the other segment's bounding box. write the tolerance only while idle.
// from acceptance to result valid a request passes the difference stage,
// multiplier stage (8 multipliers of COORD_BITS+1 bits), determinant subtract,
// and the decision register that drives result_o. throughput is one request
// per cycle while result_o.ready stays high.
// reset empties the pipeline and sets the tolerance to 7.
// when the receiver stalls, each stage holds its request and bubbles close up;
// pair_i.ready falls only once every stage is full.
module segment_intersection_test_core #(
  parameter int unsigned COORD_BITS = sit_pkg::CoordBitsDefault
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     tol_we_i,
  input  logic [sit_pkg::TolW-1:0] tol_wdata_i,
  sit_pair_if.sink                 pair_i,
  sit_result_if.source             result_o
);
  import sit_pkg::*;

  localparam int unsigned DW = 2 * COORD_BITS + 3;

  logic [TolW-1:0]           tol_q;
  pair_t                     pair;
  logic                      s1_valid, s1_ready;
  logic                      s3_valid, s3_ready;
  logic signed [COORD_BITS:0] opd [NumDet][4];
  logic [NumDet-1:0]         box1, box3;
  logic signed [DW-1:0]      det [NumDet];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TolReset;
    end else if (tol_we_i) begin
      tol_q <= tol_wdata_i;
    end
  end

  always_comb begin
    pair.first_start_x  = pair_i.first_start_x;
    pair.first_start_y  = pair_i.first_start_y;
    pair.first_end_x    = pair_i.first_end_x;
    pair.first_end_y    = pair_i.first_end_y;
    pair.second_start_x = pair_i.second_start_x;
    pair.second_start_y = pair_i.second_start_y;
    pair.second_end_x   = pair_i.second_end_x;
    pair.second_end_y   = pair_i.second_end_y;
  end

  sit_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (pair_i.valid),
    .in_ready_o (pair_i.ready),
    .pair_i     (pair),
    .out_valid_o(s1_valid),
    .out_ready_i(s1_ready),
    .opd_o      (opd),
    .in_box_o   (box1)
  );

  sit_orient #(
    .COORD_BITS(COORD_BITS)
  ) u_orient (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s1_valid),
    .in_ready_o (s1_ready),
    .opd_i      (opd),
    .in_box_i   (box1),
    .out_valid_o(s3_valid),
    .out_ready_i(s3_ready),
    .det_o      (det),
    .in_box_o   (box3)
  );

  sit_decide #(
    .COORD_BITS(COORD_BITS)
  ) u_decide (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s3_valid),
    .in_ready_o     (s3_ready),
    .det_i          (det),
    .in_box_i       (box3),
    .tol_i          (tol_q),
    .out_valid_o    (result_o.valid),
    .out_ready_i    (result_o.ready),
    .segments_meet_o(result_o.segments_meet)
  );

endmodule
